// ===== hdl/ueh_pkg.sv =====
// Package: types, constants and character helpers for the URL / HTML text codec.
`default_nettype none

package ueh_pkg;

  typedef enum logic [1:0] {
    MODE_URL_ENC  = 2'd0,
    MODE_URL_DEC  = 2'd1,
    MODE_HTML_ENC = 2'd2,
    MODE_HTML_DEC = 2'd3
  } mode_t;

  localparam int HELD_DEPTH  = 5;
  localparam int ENT_NUM     = 5;
  localparam int MAX_RESULTS = 6;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W       = $clog2(MAX_RESULTS);

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;

  localparam logic [7:0] ENT_TEXT [ENT_NUM][MAX_RESULTS] = '{
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
    '{8'h26, 8'h23, 8'h33, 8'h39, 8'h3B, 8'h00}
  };
  localparam logic [CNT_W-1:0] ENT_LEN [ENT_NUM] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd5};
  localparam logic [7:0] ENT_CHAR [ENT_NUM] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [CNT_W-1:0]            cnt;
    logic                        last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] base;
    base = (nib < 4'd10) ? 8'h30 : 8'h37;
    return {4'b0000, nib} + base;
  endfunction

  function automatic logic is_unreserved(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], 8'h2D, 8'h5F, 8'h2E, 8'h7E};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

  // Returns {valid, digit}.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) r = {1'b1, 4'(c - 8'h30)};
    else if (c inside {[8'h41:8'h46]}) r = {1'b1, 4'(c - 8'h37)};
    else if (c inside {[8'h61:8'h66]}) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  function automatic logic [7:0] plus_map(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

  function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] va;
    logic [4:0] vb;
    logic [7:0] r;
    va = hex_val(a);
    vb = hex_val(b);
    if (is_space(a) || a == CH_PLUS) r = vb[4] ? {4'b0000, vb[3:0]} : 8'h00;
    else if (a == CH_MINUS) r = vb[4] ? 8'(8'h00 - {4'b0000, vb[3:0]}) : 8'h00;
    else if (!va[4]) r = 8'h00;
    else if (!vb[4]) r = {4'b0000, va[3:0]};
    else r = {va[3:0], vb[3:0]};
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ueh_front.sv =====
// Front end: mode register, held bytes, and per-beat classification into result entries.
`default_nettype none

module ueh_front import ueh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  fifo_stat_t q_stat,
  output logic       q_push,
  output entry_t     q_entry
);

  mode_t            mode_r;
  logic [CNT_W-1:0] hc_r;
  logic [CNT_W-1:0] hc_nxt;
  logic [7:0]       held_r [HELD_DEPTH];
  logic             hold_we;
  logic [2:0]       hold_idx;
  logic [CNT_W-1:0] hc_eff;
  logic [CNT_W-1:0] len;
  logic [7:0]       cand [MAX_RESULTS];
  logic [ENT_NUM-1:0] pre;
  logic [ENT_NUM-1:0] full;
  logic [7:0]       ent_ch;
  logic [CNT_W-1:0] n;
  logic [7:0]       ob [MAX_RESULTS];
  logic             accept;
  logic [7:0]       b;

  assign b         = in_tdata;
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    hc_eff = (hc_r > CNT_W'(HELD_DEPTH)) ? '0 : hc_r;
    len    = hc_eff + CNT_W'(1);
    for (int j = 0; j < HELD_DEPTH; j++) begin
      cand[j] = (CNT_W'(j) < hc_eff) ? held_r[j] : b;
    end
    cand[HELD_DEPTH] = b;
    ent_ch = 8'h00;
    for (int k = 0; k < ENT_NUM; k++) begin
      pre[k] = (len <= ENT_LEN[k]);
      for (int j = 0; j < MAX_RESULTS; j++) begin
        if (CNT_W'(j) < len && cand[j] != ENT_TEXT[k][j]) pre[k] = 1'b0;
      end
      full[k] = pre[k] && (len == ENT_LEN[k]);
      if (full[k]) ent_ch = ENT_CHAR[k];
    end
  end

  always_comb begin
    n        = '0;
    hc_nxt   = '0;
    hold_we  = 1'b0;
    hold_idx = '0;
    for (int k = 0; k < MAX_RESULTS; k++) ob[k] = b;
    case (mode_r)
      MODE_URL_ENC: begin
        if (is_unreserved(b)) begin
          n = CNT_W'(1);
        end else begin
          n     = CNT_W'(3);
          ob[0] = CH_PCT;
          ob[1] = hex_digit(b[7:4]);
          ob[2] = hex_digit(b[3:0]);
        end
      end
      MODE_URL_DEC: begin
        case (hc_r)
          CNT_W'(1): begin
            if (in_tlast) begin
              n     = CNT_W'(2);
              ob[0] = CH_PCT;
              ob[1] = plus_map(b);
            end else begin
              hold_we  = 1'b1;
              hold_idx = 3'd1;
              hc_nxt   = CNT_W'(2);
            end
          end
          CNT_W'(2): begin
            n     = CNT_W'(1);
            ob[0] = pair_value(held_r[1], b);
          end
          default: begin
            if (b == CH_PCT) begin
              if (in_tlast) begin
                n = CNT_W'(1);
              end else begin
                hold_we = 1'b1;
                hc_nxt  = CNT_W'(1);
              end
            end else begin
              n     = CNT_W'(1);
              ob[0] = plus_map(b);
            end
          end
        endcase
      end
      MODE_HTML_ENC: begin
        n = CNT_W'(1);
        for (int k = 0; k < ENT_NUM; k++) begin
          if (ENT_CHAR[k] == b) begin
            n = ENT_LEN[k];
            for (int j = 0; j < MAX_RESULTS; j++) ob[j] = ENT_TEXT[k][j];
          end
        end
      end
      MODE_HTML_DEC: begin
        for (int k = 0; k < MAX_RESULTS; k++) ob[k] = cand[k];
        if (hc_eff == '0) begin
          if (b == CH_AMP && !in_tlast) begin
            hold_we = 1'b1;
            hc_nxt  = CNT_W'(1);
          end else begin
            n = CNT_W'(1);
          end
        end else if (|full) begin
          n     = CNT_W'(1);
          ob[0] = ent_ch;
        end else if ((|pre) && len <= CNT_W'(HELD_DEPTH)) begin
          if (in_tlast) begin
            n = len;
          end else begin
            hold_we  = 1'b1;
            hold_idx = 3'(hc_eff);
            hc_nxt   = len;
          end
        end else if (b == CH_AMP && !in_tlast) begin
          n       = hc_eff;
          hold_we = 1'b1;
          hc_nxt  = CNT_W'(1);
        end else begin
          n = len;
        end
      end
      default: begin
        n = CNT_W'(1);
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < MAX_RESULTS; k++) q_entry.bytes[k] = ob[k];
    q_entry.cnt  = n;
    q_entry.last = in_tlast;
  end

  assign q_push = accept && (n != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_URL_ENC;
      hc_r   <= '0;
    end else if (cfg_we) begin
      mode_r <= mode_t'(cfg_wdata);
      hc_r   <= '0;
    end else if (accept) begin
      hc_r <= hc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_we) begin
      held_r[hold_idx] <= b;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ueh_fifo.sv =====
// Short register queue of result entries between the front and back ends.
`default_nettype none

module ueh_fifo import ueh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  entry_t     push_entry,
  input  logic       pop,
  output entry_t     head,
  output fifo_stat_t stat
);

  entry_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r;
  logic [FIFO_AW-1:0] rp_r;
  logic [FIFO_CW-1:0] cnt_r;
  logic [FIFO_CW-1:0] cnt_nxt;

  assign head       = mem_r[rp_r];
  assign stat.full  = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + FIFO_CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - FIFO_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + FIFO_AW'(1);
      if (pop) rp_r <= rp_r + FIFO_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ueh_back.sv =====
// Back end: serializes queued entries into output beats through an output register.
`default_nettype none

module ueh_back import ueh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  entry_t     head,
  input  fifo_stat_t q_stat,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic [IDX_W-1:0] idx_r;
  logic             vld_r;
  logic [7:0]       data_r;
  logic             last_r;
  logic             load;
  logic             is_end;

  assign load   = !q_stat.empty && (!vld_r || out_tready);
  assign is_end = (CNT_W'(idx_r) + CNT_W'(1)) == head.cnt;
  assign q_pop  = load && is_end;

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= is_end ? '0 : idx_r + IDX_W'(1);
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= head.bytes[idx_r];
      last_r <= head.last && is_end;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/url_and_html_escape_codec.sv =====
// Top level of the URL percent / HTML entity text codec.
// Beats go through the queue, then the output register. Throughput: one input beat per
// cycle while the queue has room and one output beat per cycle while out_tready is high;
// the back end's one-byte-per-cycle serializer sets the rate, so expanding bytes stall
// the input once the four-entry queue fills. Synchronous active-low reset clears the mode
// to URL encode, drops held bytes, empties the queue and clears the output valid.
`default_nettype none

module url_and_html_escape_codec import ueh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,   // mode
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_byte
  output logic       out_tlast
);

  fifo_stat_t q_stat;
  logic       q_push;
  logic       q_pop;
  entry_t     q_in;
  entry_t     q_head;

  ueh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  ueh_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  ueh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/ueh_checker.sv =====
// Port-level checker for the codec top level, with its bind statement.
`default_nettype none

module ueh_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tlast))
    else $error("input beat changed while stalled");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind url_and_html_escape_codec ueh_checker u_ueh_checker (.*);

`default_nettype wire

// ===== verif/tb_url_and_html_escape_codec.sv =====
// Testbench for the URL percent / HTML entity text codec: predicted byte streams in all modes.
`timescale 1ns / 1ps

module tb_url_and_html_escape_codec import ueh_pkg::*;;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 200;
  localparam int RAND_ITEMS  = 24;

  class codec_scoreboard;
    mode_t       mode;
    logic [7:0]  held[HELD_DEPTH];
    int          held_n;
    logic [8:0]  expected_q[$];
    string       ent_str[ENT_NUM];
    logic [7:0]  ent_chr[ENT_NUM];
    string       hex_digits;
    int unsigned n_in;
    int unsigned n_out;
    int unsigned n_err;
    int unsigned n_entities;

    function new();
      mode       = MODE_URL_ENC;
      held_n     = 0;
      ent_str    = '{"&amp;", "&lt;", "&gt;", "&quot;", "&#39;"};
      ent_chr    = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};
      hex_digits = "0123456789ABCDEF";
      n_in       = 0;
      n_out      = 0;
      n_err      = 0;
      n_entities = 0;
    endfunction

    function void set_mode(mode_t m);
      mode   = m;
      held_n = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit is_plain(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
             c == "-" || c == "_" || c == "." || c == "~";
    endfunction

    function int nibble_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      return -1;
    endfunction

    function logic [7:0] plus_to_space(logic [7:0] c);
      return (c == "+") ? 8'h20 : c;
    endfunction

    // Value that a base-16 strtol reads from the two bytes after a percent sign.
    function logic [7:0] decode_pair(logic [7:0] a, logic [7:0] b);
      int da;
      int db;
      da = nibble_of(a);
      db = nibble_of(b);
      if (a == 8'h20 || (a >= 8'h09 && a <= 8'h0D) || a == "+") return (db >= 0) ? 8'(db) : 8'h00;
      if (a == "-") return (db >= 0) ? 8'(256 - db) : 8'h00;
      if (da < 0) return 8'h00;
      if (db < 0) return 8'(da);
      return 8'(da * 16 + db);
    endfunction

    // Returns 0 for no match, 1 for a proper prefix of an entity, 2 for a whole entity.
    function int entity_match(logic [7:0] seq[HELD_DEPTH + 1], int len, output logic [7:0] ch);
      int  verdict;
      bit  same;
      verdict = 0;
      ch      = 8'h00;
      for (int k = 0; k < ENT_NUM; k++) begin
        if (len <= ent_str[k].len()) begin
          same = 1'b1;
          for (int j = 0; j < len; j++) if (seq[j] != ent_str[k][j]) same = 1'b0;
          if (same && len == ent_str[k].len()) begin
            ch = ent_chr[k];
            return 2;
          end
          if (same) verdict = 1;
        end
      end
      return verdict;
    endfunction

    function void note_input(logic [7:0] b, logic last);
      logic [7:0] res[$];
      logic [7:0] seq[HELD_DEPTH + 1];
      logic [7:0] ch;
      int         verdict;
      int         k;
      n_in++;
      case (mode)
        MODE_URL_ENC: begin
          if (is_plain(b)) res.push_back(b);
          else begin
            res.push_back("%");
            res.push_back(hex_digits[b[7:4]]);
            res.push_back(hex_digits[b[3:0]]);
          end
          held_n = 0;
        end
        MODE_URL_DEC: begin
          if (held_n == 0) begin
            if (b == "%") begin
              held[0] = b;
              held_n  = 1;
            end else res.push_back(plus_to_space(b));
          end else if (held_n == 1) begin
            held[1] = b;
            held_n  = 2;
          end else begin
            res.push_back(decode_pair(held[1], b));
            held_n = 0;
          end
          if (last) begin
            if (held_n >= 1) res.push_back("%");
            if (held_n >= 2) res.push_back(plus_to_space(held[1]));
            held_n = 0;
          end
        end
        MODE_HTML_ENC: begin
          for (k = 0; k < ENT_NUM; k++) if (ent_chr[k] == b) break;
          if (k < ENT_NUM) begin
            for (int j = 0; j < ent_str[k].len(); j++) res.push_back(ent_str[k][j]);
          end else res.push_back(b);
          held_n = 0;
        end
        default: begin
          if (held_n == 0) begin
            if (b == "&") begin
              held[0] = b;
              held_n  = 1;
            end else res.push_back(b);
          end else begin
            for (int j = 0; j < held_n; j++) seq[j] = held[j];
            seq[held_n] = b;
            verdict = entity_match(seq, held_n + 1, ch);
            if (verdict == 2) begin
              res.push_back(ch);
              n_entities++;
              held_n = 0;
            end else if (verdict == 1 && held_n + 1 <= HELD_DEPTH) begin
              held[held_n] = b;
              held_n++;
            end else begin
              for (int j = 0; j < held_n; j++) res.push_back(held[j]);
              held_n = 0;
              if (b == "&") begin
                held[0] = b;
                held_n  = 1;
              end else res.push_back(b);
            end
          end
          if (last) begin
            for (int j = 0; j < held_n; j++) res.push_back(held[j]);
            held_n = 0;
          end
        end
      endcase
      foreach (res[i]) expected_q.push_back({last && (i == res.size() - 1), res[i]});
    endfunction

    function void check_result(logic [7:0] b, logic last);
      logic [8:0] exp_beat;
      n_out++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
                 $time, b, last);
        n_err++;
        return;
      end
      exp_beat = expected_q.pop_front();
      if (exp_beat[7:0] !== b) begin
        $display("%0t: out_tdata mismatch, expected %02h actual %02h", $time, exp_beat[7:0], b);
        n_err++;
      end
      if (exp_beat[8] !== last) begin
        $display("%0t: out_tlast mismatch, expected %0b actual %0b", $time, exp_beat[8], last);
        n_err++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;

  codec_scoreboard sb;
  logic [8:0]      stim_q[$];
  bit              gaps_on;
  bit              hold_pending;
  bit              hold_taken;
  int              hold_left;
  int unsigned     cycle_cnt;
  int unsigned     mode_writes;

  url_and_html_escape_codec i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d beats outstanding.", cycle_cnt, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  initial begin
    out_tready = 1'b0;
    hold_taken = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_pending && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = !(gaps_on && $urandom_range(0, 99) < 16);
      end
    end
  end

  task automatic add_text(input string s, input logic lst);
    for (int i = 0; i < s.len(); i++) stim_q.push_back({lst && (i == s.len() - 1), s[i]});
  endtask

  function automatic logic [7:0] pair_char();
    string hexes;
    hexes = "0123456789abcdefABCDEF";
    case ($urandom_range(0, 5))
      0, 1:    return hexes[$urandom_range(0, hexes.len() - 1)];
      2:       return ($urandom_range(0, 1) != 0) ? 8'h20 : 8'($urandom_range(9, 13));
      3:       return ($urandom_range(0, 1) != 0) ? 8'h2B : 8'h2D;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] text_char();
    string specials;
    specials = "&<>\"'%+-_.~ ;#";
    if ($urandom_range(0, 99) < 40) return specials[$urandom_range(0, specials.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic build_random(input mode_t m);
    logic [7:0] seg[$];
    int         k;
    int         cut;
    while (stim_q.size() < RAND_ITEMS) begin
      seg.delete();
      case (m)
        MODE_URL_DEC: begin
          if ($urandom_range(0, 99) < 55) begin
            seg.push_back("%");
            seg.push_back(pair_char());
            seg.push_back(pair_char());
          end else seg.push_back(text_char());
        end
        MODE_HTML_DEC: begin
          if ($urandom_range(0, 99) < 55) begin
            k   = $urandom_range(0, ENT_NUM - 1);
            cut = ($urandom_range(0, 99) < 70) ? sb.ent_str[k].len()
                                               : $urandom_range(1, sb.ent_str[k].len() - 1);
            for (int j = 0; j < cut; j++) seg.push_back(sb.ent_str[k][j]);
            if (cut < sb.ent_str[k].len()) seg.push_back(text_char());
          end else seg.push_back(text_char());
        end
        default: seg.push_back(text_char());
      endcase
      foreach (seg[i]) stim_q.push_back({1'b0, seg[i]});
      if ($urandom_range(0, 19) == 0) stim_q[stim_q.size() - 1][8] = 1'b1;
    end
    stim_q[stim_q.size() - 1][8] = 1'b1;
  endtask

  task automatic drive_stim();
    logic [8:0] beat;
    while (stim_q.size() > 0) begin
      beat = stim_q.pop_front();
      while (gaps_on && $urandom_range(0, 99) < 16) begin
        in_tvalid = 1'b0;
        @(negedge clk);
      end
      in_tvalid = 1'b1;
      in_tdata  = beat[7:0];
      in_tlast  = beat[8];
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      sb.note_input(beat[7:0], beat[8]);
      @(negedge clk);
    end
    in_tvalid = 1'b0;
  endtask

  task automatic write_mode(input mode_t m);
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_mode(m);
    mode_writes++;
  endtask

  mode_t rand_modes[8] = '{MODE_URL_ENC, MODE_HTML_DEC, MODE_URL_DEC, MODE_HTML_ENC,
                           MODE_URL_DEC, MODE_HTML_DEC, MODE_URL_ENC, MODE_HTML_ENC};

  initial begin
    sb           = new();
    cycle_cnt    = 0;
    mode_writes  = 0;
    gaps_on      = 1'b1;
    hold_pending = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = MODE_URL_ENC;
    in_tvalid    = 1'b0;
    in_tdata     = 8'h00;
    in_tlast     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_mode(MODE_URL_ENC);
    stim_q.push_back({1'b0, 8'h00});
    stim_q.push_back({1'b0, 8'hFF});
    add_text("~A", 1'b1);
    drive_stim();

    write_mode(MODE_URL_DEC);
    add_text("%-3+", 1'b0);
    add_text("%+", 1'b1);
    drive_stim();

    write_mode(MODE_HTML_ENC);
    add_text("&<>\"'", 1'b1);
    drive_stim();

    write_mode(MODE_HTML_DEC);
    add_text("&lt;&&gt;", 1'b0);
    add_text("&q", 1'b1);
    drive_stim();

    foreach (rand_modes[p]) begin
      write_mode(rand_modes[p]);
      build_random(rand_modes[p]);
      gaps_on = (p != 4);
      if (p == 3) hold_pending = 1'b1;
      drive_stim();
    end
    gaps_on = 1'b1;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d input beats over %0d mode settings, checked %0d output beats.",
             sb.n_in, mode_writes, sb.n_out);
    $display("Decoded %0d whole HTML entities; one long output stall forced input backpressure.",
             sb.n_entities);
    if (sb.n_err == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
